@@ src/gffra_pkg.sv @@
// shared types and constants for the grid first-fit region allocator
// no dependencies; used by the controller, the datapath and the top level
`timescale 1ns / 1ps

package gffra_pkg;

  localparam int GRID_COLS = 16;
  localparam int GRID_ROWS = 16;

  // column and row position widths
  localparam int XW = $clog2(GRID_COLS);
  localparam int YW = $clog2(GRID_ROWS);

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic mark;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic trivial;
    logic hit;
    logic last_x;
  } dp_status_t;

endpackage

@@ src/gffra_ctrl.sv @@
// controller state machine: request handshake, column scan sequencing, result handshake
// depends on gffra_pkg
`timescale 1ns / 1ps

module gffra_ctrl import gffra_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = status.trivial ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.hit || status.last_x) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!rsp_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req_stall = 1'b1;
    rsp_valid = 1'b0;
    cmd       = '0;
    unique case (state)
      ST_IDLE: begin
        req_stall = 1'b0;
        cmd.load  = req_valid;
      end
      ST_SCAN: begin
        cmd.mark = status.hit;
        cmd.step = !status.hit && !status.last_x;
      end
      ST_DONE: begin
        rsp_valid = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

@@ src/gffra_dp.sv @@
// datapath: occupancy bitmap, column counter, per-column row fit search, result registers
// depends on gffra_pkg
`timescale 1ns / 1ps

module gffra_dp import gffra_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  input  logic        kind,
  input  logic [4:0]  width_blocks,
  input  logic [4:0]  height_blocks,
  output dp_status_t  status,
  output logic        placed,
  output logic [3:0]  x_block,
  output logic [3:0]  y_block
);

  logic [GRID_COLS-1:0]   rows [GRID_ROWS];
  logic [4:0]             w_req;
  logic [4:0]             h_req;
  logic [XW-1:0]          x_pos;

  logic [GRID_COLS-1:0]   col_mask;
  logic [GRID_ROWS-1:0]   row_free;
  logic [GRID_ROWS-1:0]   h_mask;
  logic [GRID_ROWS-1:0]   fit;
  logic [GRID_ROWS-1:0]   row_sel;
  logic [2*GRID_ROWS-1:0] free_ext;
  logic [2*GRID_ROWS-1:0] window;
  logic [YW-1:0]          hit_y;

  assign status.trivial = (kind == KIND_CLEAR) || (width_blocks == 5'd0) ||
                          (height_blocks == 5'd0) || (int'(width_blocks) > GRID_COLS) ||
                          (int'(height_blocks) > GRID_ROWS);
  assign status.last_x  = (int'(x_pos) + int'(w_req)) >= GRID_COLS;
  assign status.hit     = |fit;

  // columns covered by the rectangle at the current x
  always_comb begin
    for (int c = 0; c < GRID_COLS; c++) begin
      col_mask[c] = (c >= int'(x_pos)) && (c < int'(x_pos) + int'(w_req));
    end
  end

  always_comb begin
    for (int r = 0; r < GRID_ROWS; r++) begin
      row_free[r] = ~|(rows[r] & col_mask);
      h_mask[r]   = r < int'(h_req);
    end
  end

  // rows past the bottom read as blocked, so a fit never leaves the grid
  assign free_ext = {{GRID_ROWS{1'b0}}, row_free};

  always_comb begin
    window = '0;
    for (int y = 0; y < GRID_ROWS; y++) begin
      window = free_ext >> y;
      fit[y] = &(window[GRID_ROWS-1:0] | ~h_mask);
    end
  end

  // lowest fitting row wins
  always_comb begin
    hit_y = '0;
    for (int y = GRID_ROWS - 1; y >= 0; y--) begin
      if (fit[y]) begin
        hit_y = YW'(y);
      end
    end
  end

  always_comb begin
    for (int r = 0; r < GRID_ROWS; r++) begin
      row_sel[r] = (r >= int'(hit_y)) && (r < int'(hit_y) + int'(h_req));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < GRID_ROWS; r++) begin
        rows[r] <= '0;
      end
    end else if (cmd.load && kind == KIND_CLEAR) begin
      for (int r = 0; r < GRID_ROWS; r++) begin
        rows[r] <= '0;
      end
    end else if (cmd.mark) begin
      for (int r = 0; r < GRID_ROWS; r++) begin
        if (row_sel[r]) begin
          rows[r] <= rows[r] | col_mask;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      w_req   <= width_blocks;
      h_req   <= height_blocks;
      x_pos   <= '0;
      placed  <= 1'b0;
      x_block <= '0;
      y_block <= '0;
    end else begin
      if (cmd.step) begin
        x_pos <= x_pos + XW'(1);
      end
      if (cmd.mark) begin
        placed  <= 1'b1;
        x_block <= 4'(x_pos);
        y_block <= 4'(hit_y);
      end
    end
  end

endmodule

@@ src/grid_first_fit_region_allocator.sv @@
// top level of the grid first-fit region allocator
// depends on gffra_pkg, gffra_ctrl and gffra_dp
//
//   channel | handshake            | beat fields
//   --------+----------------------+-----------------------------------
//   req     | req_valid, req_stall | kind, width_blocks, height_blocks
//   rsp     | rsp_valid, rsp_stall | placed, x_block, y_block
//
// an allocate beat tries candidate columns x = 0 .. GRID_COLS - width in order,
// up to the first hit; the column scan checks every row of one column position in
// parallel and marks the area on a hit
// a clear beat or a zero or oversized size skips the scan; the result shows next cycle
// one beat is in flight at a time; req_stall is high from acceptance until the
// result beat is taken, and rsp_stall holds the result as long as needed
// reset empties the grid at once and leaves the block idle
`timescale 1ns / 1ps

module grid_first_fit_region_allocator import gffra_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  logic       kind,
  input  logic [4:0] width_blocks,
  input  logic [4:0] height_blocks,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output logic       placed,
  output logic [3:0] x_block,
  output logic [3:0] y_block
);

  dp_cmd_t    cmd;
  dp_status_t status;

  gffra_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .status    (status),
    .cmd       (cmd)
  );

  gffra_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .kind          (kind),
    .width_blocks  (width_blocks),
    .height_blocks (height_blocks),
    .status        (status),
    .placed        (placed),
    .x_block       (x_block),
    .y_block       (y_block)
  );

`ifndef NO_ASSERTIONS
  // no new request while a result is pending
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> req_stall)
    else $error("request taken while result pending");

  // an accepted request closes the request side until its result is taken
  a_stall_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request side open right after accept");

  // failed or clear results report the origin
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !placed) |-> (x_block == 4'd0 && y_block == 4'd0))
    else $error("nonzero position on unplaced result");

  // the scan never issues step and mark together
  a_cmd_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.step && cmd.mark))
    else $error("step and mark in the same cycle");
`endif

endmodule

@@ tb/grid_first_fit_region_allocator_tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench for grid_first_fit_region_allocator: directed and random beats
// depends on gffra_pkg and the allocator rtl; keeps its own occupancy grid for prediction

module grid_first_fit_region_allocator_tb;
  import gffra_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_WAIT = 17;
  localparam int RANDOM_BEATS = 400;

  typedef struct packed {
    logic       kind;
    logic [4:0] w;
    logic [4:0] h;
    logic       drain;
  } req_beat_t;

  typedef struct packed {
    logic       placed;
    logic [3:0] x;
    logic [3:0] y;
  } placement_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       req_valid = 1'b0;
  logic       req_stall;
  logic       kind = KIND_ALLOC;
  logic [4:0] width_blocks = 5'd0;
  logic [4:0] height_blocks = 5'd0;
  logic       rsp_valid;
  logic       rsp_stall = 1'b0;
  logic       placed;
  logic [3:0] x_block;
  logic [3:0] y_block;

  logic [GRID_COLS-1:0] occ_rows [GRID_ROWS];
  req_beat_t  pending_q [$];
  placement_t placement_q [$];
  int sent_count = 0;
  int back_count = 0;
  int error_count = 0;
  int cycle_count = 0;
  int gap_left = 0;
  int stall_left = 0;

  grid_first_fit_region_allocator uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .kind(kind),
    .width_blocks(width_blocks),
    .height_blocks(height_blocks),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .placed(placed),
    .x_block(x_block),
    .y_block(y_block)
  );

  always #6 clk = ~clk;

  // quiet windows give stretches with no idling on either side
  function automatic int draw_wait();
    if ((cycle_count % 3000) < 600) return 0;
    return $urandom_range(0, MAX_WAIT);
  endfunction

  // first fit, column outer and row inner; marks the grid on a hit, empties it on a clear
  function automatic placement_t place_region(logic k, logic [4:0] w, logic [4:0] h);
    placement_t res;
    logic [63:0] span;
    logic fits;
    int xs, ys, r;
    res = '0;
    if (k == KIND_CLEAR) begin
      for (r = 0; r < GRID_ROWS; r++) occ_rows[r] = '0;
    end else if (w != 0 && h != 0 && w <= GRID_COLS && h <= GRID_ROWS) begin
      for (xs = 0; xs + w <= GRID_COLS && !res.placed; xs++) begin
        span = ((64'd1 << w) - 64'd1) << xs;
        for (ys = 0; ys + h <= GRID_ROWS && !res.placed; ys++) begin
          fits = 1'b1;
          for (r = ys; r < ys + h; r++)
            if ((occ_rows[r] & span[GRID_COLS-1:0]) != '0) fits = 1'b0;
          if (fits) begin
            for (r = ys; r < ys + h; r++) occ_rows[r] = occ_rows[r] | span[GRID_COLS-1:0];
            res.placed = 1'b1;
            res.x = xs[3:0];
            res.y = ys[3:0];
          end
        end
      end
    end
    return res;
  endfunction

  // a drain beat waits until every placement has come back
  function automatic bit may_launch();
    if (pending_q.size() == 0) return 1'b0;
    return !pending_q[0].drain || (sent_count == back_count);
  endfunction

  task automatic launch_beat();
    req_beat_t b;
    b = pending_q.pop_front();
    req_valid <= 1'b1;
    kind <= b.kind;
    width_blocks <= b.w;
    height_blocks <= b.h;
  endtask

  task automatic queue_beat(logic k, logic [4:0] w, logic [4:0] h, logic d);
    req_beat_t b;
    b.kind = k;
    b.w = w;
    b.h = h;
    b.drain = d;
    pending_q = {pending_q, b};
  endtask

  // mostly small sizes so several regions fit, some mid and some out of range
  function automatic logic [4:0] pick_size();
    int sel, v;
    sel = $urandom_range(0, 19);
    if (sel < 14) return 5'($urandom_range(1, 5));
    if (sel < 18) return 5'($urandom_range(6, 16));
    if (sel == 18) begin
      v = $urandom_range(16, 31);
      return (v == 16) ? 5'd0 : 5'(v);
    end
    return 5'($urandom_range(0, 31));
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (req_valid && !req_stall) begin
      placement_q = {placement_q, place_region(kind, width_blocks, height_blocks)};
      sent_count++;
      gap_left = draw_wait();
      if (gap_left == 0 && may_launch()) begin
        launch_beat();
      end else begin
        req_valid <= 1'b0;
      end
    end else if (!req_valid) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (may_launch()) begin
        launch_beat();
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    placement_t want;
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (placement_q.size() == 0) begin
          $display("%0t: result beat with nothing expected: placed %0d x %0d y %0d",
                   $time, placed, x_block, y_block);
          error_count++;
        end else begin
          want = placement_q.pop_front();
          if (placed !== want.placed) begin
            $display("%0t: placed expected %0d got %0d", $time, want.placed, placed);
            error_count++;
          end
          if (x_block !== want.x) begin
            $display("%0t: x_block expected %0d got %0d", $time, want.x, x_block);
            error_count++;
          end
          if (y_block !== want.y) begin
            $display("%0t: y_block expected %0d got %0d", $time, want.y, y_block);
            error_count++;
          end
          back_count <= back_count + 1;
        end
        stall_left = draw_wait();
      end else if (stall_left > 0) begin
        stall_left--;
      end
      rsp_stall <= (stall_left != 0);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("grid_first_fit_region_allocator_tb: FAIL");
      $finish;
    end
  end

  initial begin
    int n;
    logic k;
    for (n = 0; n < GRID_ROWS; n++) occ_rows[n] = '0;

    queue_beat(KIND_ALLOC, 5'd1, 5'd1, 1'b0);
    queue_beat(KIND_ALLOC, 5'd0, 5'd3, 1'b0);    // zero width
    queue_beat(KIND_ALLOC, 5'd5, 5'd0, 1'b0);    // zero height
    queue_beat(KIND_ALLOC, 5'd17, 5'd1, 1'b0);   // too wide
    queue_beat(KIND_ALLOC, 5'd1, 5'd17, 1'b0);   // too tall
    queue_beat(KIND_ALLOC, 5'd31, 5'd31, 1'b0);
    queue_beat(KIND_ALLOC, 5'd16, 5'd16, 1'b0);  // blocked by the corner block
    queue_beat(KIND_CLEAR, 5'd31, 5'd31, 1'b0);
    queue_beat(KIND_ALLOC, 5'd16, 5'd16, 1'b1);
    queue_beat(KIND_ALLOC, 5'd1, 5'd1, 1'b0);    // grid full
    queue_beat(KIND_CLEAR, 5'd0, 5'd0, 1'b0);
    queue_beat(KIND_ALLOC, 5'd16, 5'd1, 1'b0);
    queue_beat(KIND_ALLOC, 5'd1, 5'd16, 1'b0);
    queue_beat(KIND_ALLOC, 5'd1, 5'd15, 1'b0);
    queue_beat(KIND_ALLOC, 5'd15, 5'd15, 1'b0);
    queue_beat(KIND_ALLOC, 5'd1, 5'd1, 1'b0);
    queue_beat(KIND_CLEAR, 5'd10, 5'd21, 1'b1);
    queue_beat(KIND_ALLOC, 5'd3, 5'd5, 1'b0);
    queue_beat(KIND_ALLOC, 5'd7, 5'd2, 1'b0);
    queue_beat(KIND_ALLOC, 5'd2, 5'd9, 1'b0);
    queue_beat(KIND_ALLOC, 5'd14, 5'd16, 1'b0);
    queue_beat(KIND_ALLOC, 5'd1, 5'd16, 1'b0);
    queue_beat(KIND_CLEAR, 5'd21, 5'd10, 1'b0);

    for (n = 0; n < RANDOM_BEATS; n++) begin
      k = ($urandom_range(0, 15) == 0) ? KIND_CLEAR : KIND_ALLOC;
      queue_beat(k, pick_size(), pick_size(), $urandom_range(0, 39) == 0);
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (!(pending_q.size() == 0 && !req_valid && back_count == sent_count))
      @(posedge clk);
    repeat (40) @(posedge clk);
    if (error_count == 0 && placement_q.size() == 0) begin
      $display("grid_first_fit_region_allocator_tb: PASS");
    end else begin
      $display("grid_first_fit_region_allocator_tb: FAIL");
    end
    $finish;
  end

endmodule

@@ grid_first_fit_region_allocator.f @@
src/gffra_pkg.sv
src/gffra_ctrl.sv
src/gffra_dp.sv
src/grid_first_fit_region_allocator.sv
tb/grid_first_fit_region_allocator_tb.sv
